FILE: src/u2l9_pkg.sv
// Package for the UTF-8 to Latin-9 decoder: the queue item, sizes and
// the code point to Latin-9 mapping function. It depends on nothing else.
package u2l9_pkg;

  localparam longint unsigned MAX_STRING_BYTES = 64'd65535;
  localparam logic [15:0] CNT_LIMIT =
    (MAX_STRING_BYTES > 64'd65535) ? 16'hFFFF : MAX_STRING_BYTES[15:0];

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_ascii;
    logic       is_cont;
    logic [2:0] lead_len;
    logic [4:0] lead_bits;
  } u2l9_item_t;

  // Returns {hit, byte}; code points below 256 pass through as their own byte, others hit only if in the table.
  function automatic logic [8:0] map_latin9(input logic [30:0] cp);
    logic [8:0] res;
    res = 9'd0;
    if (cp < 31'd256) begin
      res = {1'b1, cp[7:0]};
    end else begin
      case (cp)
        31'h0152: res = {1'b1, 8'd188};
        31'h0153: res = {1'b1, 8'd189};
        31'h0160: res = {1'b1, 8'd166};
        31'h0161: res = {1'b1, 8'd168};
        31'h0178: res = {1'b1, 8'd190};
        31'h017D: res = {1'b1, 8'd180};
        31'h017E: res = {1'b1, 8'd184};
        31'h20AC: res = {1'b1, 8'd164};
        default:  res = 9'd0;
      endcase
    end
    return res;
  endfunction

endpackage

FILE: src/utf8_to_latin9_decoder.sv
// UTF-8 to Latin-9 decoder, top level: front stage, queue and decode stage.
// A byte goes through the front register, the queue and the output register.
// Throughput: one byte per cycle while the output side does not stall.
// The two-entry queue and the output register let either side stall alone.
// Reset (rst_ni low, asynchronous) empties the pipeline; data registers are not reset.
// Depends on u2l9_pkg, u2l9_front, u2l9_fifo and u2l9_back.
module utf8_to_latin9_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [7:0] in_byte
  input  logic [u2l9_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tlast: last_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [7:0] out_byte, [23:8] out_count
  output logic [u2l9_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: byte_valid
  output logic        m_axis_tuser_o,
  // tlast: end_of_string
  output logic        m_axis_tlast_o
);
  import u2l9_pkg::*;

  logic       push, push_ready, pop, pop_valid;
  u2l9_item_t push_item, pop_item;
  logic [7:0] out_byte;
  logic [15:0] out_count;

  u2l9_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i[7:0]),
    .in_last_i    (s_axis_tlast_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  u2l9_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item)
  );

  u2l9_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_item_i      (pop_item),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (out_byte),
    .byte_valid_o    (m_axis_tuser_o),
    .end_of_string_o (m_axis_tlast_o),
    .out_count_o     (out_count)
  );

  assign m_axis_tdata_o = {out_count, out_byte};

endmodule

FILE: src/u2l9_front.sv
// Front stage: accepts raw bytes and classifies them into queue items.
// Depends on u2l9_pkg.
module u2l9_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                push_o,
  output u2l9_pkg::u2l9_item_t push_item_o,
  input  logic                push_ready_i
);
  import u2l9_pkg::*;

  logic       valid_q, valid_d;
  u2l9_item_t item_q, item_d;
  u2l9_item_t cls;

  always_comb begin
    cls           = '0;
    cls.data      = in_byte_i;
    cls.last      = in_last_i;
    cls.is_ascii  = ~in_byte_i[7];
    cls.is_cont   = (in_byte_i[7:6] == 2'b10);
    case (in_byte_i) inside
      [8'hC0:8'hDF]: begin
        cls.lead_len  = 3'd1;
        cls.lead_bits = in_byte_i[4:0];
      end
      [8'hE0:8'hEF]: begin
        cls.lead_len  = 3'd2;
        cls.lead_bits = {1'b0, in_byte_i[3:0]};
      end
      [8'hF0:8'hF7]: begin
        cls.lead_len  = 3'd3;
        cls.lead_bits = {2'b0, in_byte_i[2:0]};
      end
      [8'hF8:8'hFB]: begin
        cls.lead_len  = 3'd4;
        cls.lead_bits = {3'b0, in_byte_i[1:0]};
      end
      [8'hFC:8'hFD]: begin
        cls.lead_len  = 3'd5;
        cls.lead_bits = {4'b0, in_byte_i[0]};
      end
      default: begin
        cls.lead_len  = 3'd0;
        cls.lead_bits = 5'd0;
      end
    endcase
  end

  assign in_ready_o  = ~valid_q | push_ready_i;
  assign push_o      = valid_q;
  assign push_item_o = item_q;

  always_comb begin
    valid_d = valid_q & ~push_ready_i;
    item_d  = item_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
      item_d  = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

FILE: src/u2l9_fifo.sv
// Two-entry queue that parts the front stage from the decode stage.
// Depends on u2l9_pkg.
module u2l9_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u2l9_pkg::u2l9_item_t push_item_i,
  output logic                push_ready_o,
  input  logic                pop_i,
  output logic                pop_valid_o,
  output u2l9_pkg::u2l9_item_t pop_item_o
);
  import u2l9_pkg::*;

  u2l9_item_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(do_pop);
    count_d  = count_q + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("Queue fill count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Empty queue with pointers apart.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue count did not follow a lone push.");

endmodule

FILE: src/u2l9_back.sv
// Decode stage: runs the UTF-8 sequence state over queue items and holds
// each result in an output register. Depends on u2l9_pkg.
module u2l9_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  u2l9_pkg::u2l9_item_t pop_item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                end_of_string_o,
  output logic [15:0]         out_count_o
);
  import u2l9_pkg::*;

  logic [2:0]  rem_q, rem_d;
  logic [30:0] code_q, code_d;
  logic        ok_q, ok_d;
  logic [15:0] cnt_q, cnt_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        bv_q, bv_d;
  logic        eos_q, eos_d;
  logic [15:0] oc_q, oc_d;
  logic        emit;
  logic [7:0]  ob;
  logic [8:0]  map_res;
  logic        take;

  assign pop_o = pop_valid_i & (~ov_q | out_ready_i);
  assign take  = pop_o;

  always_comb begin
    rem_d   = rem_q;
    code_d  = code_q;
    ok_d    = ok_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    ob      = 8'd0;
    map_res = 9'd0;
    ov_d    = ov_q & ~out_ready_i;
    ob_d    = ob_q;
    bv_d    = bv_q;
    eos_d   = eos_q;
    oc_d    = oc_q;
    if (take) begin
      if (rem_q != 3'd0) begin
        ok_d    = ok_q & pop_item_i.is_cont;
        code_d  = {code_q[24:0], pop_item_i.data[5:0]};
        rem_d   = rem_q - 3'd1;
        map_res = map_latin9(code_d);
        if (rem_d == 3'd0 && ok_d && map_res[8]) begin
          emit = 1'b1;
          ob   = map_res[7:0];
        end
      end else if (pop_item_i.is_ascii) begin
        emit = 1'b1;
        ob   = pop_item_i.data;
      end else if (pop_item_i.lead_len != 3'd0) begin
        rem_d  = pop_item_i.lead_len;
        code_d = {26'd0, pop_item_i.lead_bits};
        ok_d   = 1'b1;
      end
      if (emit && cnt_q < CNT_LIMIT) begin
        cnt_d = cnt_q + 16'd1;
      end
      if (emit || pop_item_i.last) begin
        ov_d  = 1'b1;
        ob_d  = ob;
        bv_d  = emit;
        eos_d = pop_item_i.last;
        oc_d  = cnt_d;
      end
      if (pop_item_i.last) begin
        rem_d  = 3'd0;
        code_d = 31'd0;
        ok_d   = 1'b0;
        cnt_d  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 3'd0;
      code_q <= 31'd0;
      ok_q   <= 1'b0;
      cnt_q  <= 16'd0;
      ov_q   <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      code_q <= code_d;
      ok_q   <= ok_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q  <= ob_d;
    bv_q  <= bv_d;
    eos_q <= eos_d;
    oc_q  <= oc_d;
  end

  assign out_valid_o     = ov_q;
  assign out_byte_o      = ob_q;
  assign byte_valid_o    = bv_q;
  assign end_of_string_o = eos_q;
  assign out_count_o     = oc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd5)
    else $error("Sequence length beyond six bytes.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !bv_q) |-> (eos_q && ob_q == 8'd0))
    else $error("Result without a byte that does not end the string.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(oc_q) && $stable(ob_q)))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LIMIT)
    else $error("Emitted count above its limit.");

endmodule
